### rtl/gregorian_date_calendar_fields_assert.svh
// Assertion macros for the calendar field pipeline.
// Files that check their own logic take this header by include; it depends on nothing.
`ifndef GREGORIAN_DATE_CALENDAR_FIELDS_ASSERT_SVH
`define GREGORIAN_DATE_CALENDAR_FIELDS_ASSERT_SVH
`ifndef SYNTHESIS
`define GDCF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define GDCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GDCF_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GDCF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/gdcf_pkg.sv
// Types, constants and month tables for the calendar field pipeline.
// Used by every module of the block; depends on nothing.
package gdcf_pkg;

  localparam logic [13:0] YEAR_MAX      = 14'd9999;
  localparam logic [8:0]  YEAR_LEN      = 9'd365;
  localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
  localparam logic [5:0]  WEEK_LONG     = 6'd53;
  localparam logic [5:0]  WEEK_SHORT    = 6'd52;
  localparam logic [13:0] YEAR_SHIFT    = 14'd400;

  // Reciprocal multipliers for division by 100 and by 7.
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SH  = 19;
  localparam logic [11:0] DIV7_MUL   = 12'd2341;
  localparam int          DIV7_SH    = 14;

  localparam logic [2:0] WD_SUNDAY    = 3'd0;
  localparam logic [2:0] ISO_SUNDAY   = 3'd7;
  localparam logic [2:0] DEC31_THU    = 3'd4;
  localparam logic [2:0] DEC31_FRI    = 3'd5;

  typedef struct packed {
    logic [13:0] year_value;
    logic [3:0]  month_value;
    logic [4:0]  day_value;
  } date_in_t;

  typedef struct packed {
    logic        date_valid;
    logic        leap_flag;
    logic [8:0]  ordinal_day;
    logic [2:0]  weekday_sunday;
    logic [2:0]  weekday_iso;
    logic [5:0]  week_sunday_based;
    logic [5:0]  week_iso;
  } date_out_t;

  typedef struct packed {
    logic        date_ok;
    logic        leap;
    logic        prev_leap;
    logic [8:0]  doy;
    logic [14:0] yadj;
    logic [7:0]  cent;
    logic [2:0]  sak;
    logic [4:0]  dd;
  } ydate_t;

  typedef struct packed {
    logic        date_ok;
    logic        leap;
    logic        prev_leap;
    logic [8:0]  doy;
    logic [2:0]  wd;
  } wday_t;

  function automatic logic [4:0] month_len(input logic [3:0] mm, input logic leap);
    logic [4:0] len;
    unique case (mm)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before the given one, common year.
  function automatic logic [8:0] cum_days(input logic [3:0] mm);
    logic [8:0] days;
    unique case (mm)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  // Month offsets of the weekday formula.
  function automatic logic [2:0] sak_off(input logic [3:0] mm);
    logic [2:0] off;
    unique case (mm)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

### rtl/gdcf_year.sv
// Year stages: century quotient, leap rules, date check and day of year.
// Depends on gdcf_pkg.
module gdcf_year
  import gdcf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  date_in_t in_item,
  output logic     yr_vld,
  output ydate_t   yr
);

  logic        s1_vld_r;
  date_in_t    s1_item_r;
  logic [7:0]  s1_q100_r;
  logic [26:0] q100_prod;
  logic [7:0]  q100_nxt;

  logic        s2_vld_r;
  ydate_t      s2_r;
  ydate_t      s2_nxt;

  logic [13:0] yy;
  logic [3:0]  mm;
  logic [4:0]  dd;
  logic [13:0] rem_full;
  logic [6:0]  rem;
  logic        r0;
  logic        q4;
  logic        early_mo;
  logic        leap;

  assign q100_prod = 27'(in_item.year_value) * 27'(DIV100_MUL);
  assign q100_nxt  = 8'(q100_prod >> DIV100_SH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= in_item;
    s1_q100_r <= q100_nxt;
    s2_r      <= s2_nxt;
  end

  always_comb begin
    yy       = s1_item_r.year_value;
    mm       = s1_item_r.month_value;
    dd       = s1_item_r.day_value;
    rem_full = yy - {s1_q100_r, 6'b0} - 14'({s1_q100_r, 5'b0}) - 14'({s1_q100_r, 2'b0});
    rem      = rem_full[6:0];
    r0       = (rem == 7'd0);
    q4       = (s1_q100_r[1:0] == 2'd0);
    early_mo = (mm < 4'd3);
    leap     = (yy[1:0] == 2'd0) && (!r0 || q4);

    s2_nxt.leap      = leap;
    s2_nxt.prev_leap = (yy != 14'd0) && (yy[1:0] == 2'd1) && ((rem != 7'd1) || q4);
    s2_nxt.date_ok   = (yy <= YEAR_MAX) && (mm >= 4'd1) && (mm <= 4'd12) && (dd >= 5'd1)
                       && (dd <= month_len(mm, leap));
    s2_nxt.doy       = cum_days(mm) + 9'(dd) + 9'(leap && (mm > 4'd2));
    s2_nxt.yadj      = 15'(yy) + 15'(YEAR_SHIFT) - 15'(early_mo);
    s2_nxt.cent      = s1_q100_r + 8'd4 - 8'(early_mo && r0);
    s2_nxt.sak       = sak_off(mm);
    s2_nxt.dd        = dd;
  end

  assign yr_vld = s2_vld_r;
  assign yr     = s2_r;

endmodule

### rtl/gdcf_weekday.sv
// Weekday stages: the day-count sum, then its remainder modulo seven.
// Depends on gdcf_pkg.
module gdcf_weekday
  import gdcf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   yr_vld,
  input  ydate_t yr,
  output logic   wd_vld,
  output wday_t  wd
);

  logic        s3_vld_r;
  ydate_t      s3_r;
  logic [15:0] sum_r;
  logic [15:0] sum_nxt;

  logic        s4_vld_r;
  wday_t       s4_r;
  wday_t       s4_nxt;

  logic [5:0]  fold1;
  logic [3:0]  fold2;

  assign sum_nxt = 16'(yr.yadj) + 16'(yr.yadj >> 2) - 16'(yr.cent) + 16'(yr.cent >> 2)
                   + 16'(yr.sak) + 16'(yr.dd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= yr_vld;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r  <= yr;
    sum_r <= sum_nxt;
    s4_r  <= s4_nxt;
  end

  // Eight is one modulo seven, so octal digits are summed twice before a final subtract.
  always_comb begin
    fold1 = 6'(sum_r[2:0]) + 6'(sum_r[5:3]) + 6'(sum_r[8:6]) + 6'(sum_r[11:9])
            + 6'(sum_r[14:12]) + 6'(sum_r[15]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);

    s4_nxt.date_ok   = s3_r.date_ok;
    s4_nxt.leap      = s3_r.leap;
    s4_nxt.prev_leap = s3_r.prev_leap;
    s4_nxt.doy       = s3_r.doy;
    s4_nxt.wd        = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
  end

  assign wd_vld = s4_vld_r;
  assign wd     = s4_r;

endmodule

### rtl/gdcf_week.sv
// Week stages: ISO weekday, Sunday-based week and ISO week, then the output register.
// Depends on gdcf_pkg.
module gdcf_week
  import gdcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wd_vld,
  input  wday_t     wd,
  output logic      out_vld,
  output date_out_t out_item
);

  typedef struct packed {
    logic        date_ok;
    logic        leap;
    logic [8:0]  doy;
    logic [2:0]  wd;
    logic [2:0]  iso;
    logic [5:0]  wk_sun;
    logic        early;
    logic        prev53;
    logic        late;
    logic [8:0]  tm1;
  } wk_t;

  logic        s5_vld_r;
  wk_t         s5_r;
  wk_t         s5_nxt;
  logic        s6_vld_r;
  date_out_t   s6_r;
  date_out_t   s6_nxt;

  logic [2:0]  iso;
  logic [8:0]  sun_num;
  logic [20:0] sun_prod;
  logic [9:0]  thu;
  logic [9:0]  thu2;
  logic [2:0]  dec31;
  logic [8:0]  ylen;
  logic [20:0] iso_prod;
  logic [5:0]  iso_q;
  logic [5:0]  wk_iso;

  always_comb begin
    iso      = (wd.wd == WD_SUNDAY) ? ISO_SUNDAY : wd.wd;
    sun_num  = wd.doy + 9'd6 - 9'(wd.wd);
    sun_prod = 21'(sun_num) * 21'(DIV7_MUL);
    thu      = 10'(wd.doy) + 10'd4;
    thu2     = thu - 10'(iso);
    dec31    = iso - wd.doy[2:0];
    ylen     = wd.leap ? LEAP_YEAR_LEN : YEAR_LEN;

    s5_nxt.date_ok = wd.date_ok;
    s5_nxt.leap    = wd.leap;
    s5_nxt.doy     = wd.doy;
    s5_nxt.wd      = wd.wd;
    s5_nxt.iso     = iso;
    s5_nxt.wk_sun  = 6'(sun_prod >> DIV7_SH);
    s5_nxt.early   = (thu <= 10'(iso));
    s5_nxt.prev53  = (dec31 == DEC31_THU) || ((dec31 == DEC31_FRI) && wd.prev_leap);
    s5_nxt.late    = (thu2 > 10'(ylen));
    s5_nxt.tm1     = 9'(thu2 - 10'd1);
  end

  always_comb begin
    iso_prod = 21'(s5_r.tm1) * 21'(DIV7_MUL);
    iso_q    = 6'(iso_prod >> DIV7_SH) + 6'd1;
    if (s5_r.early) begin
      wk_iso = s5_r.prev53 ? WEEK_LONG : WEEK_SHORT;
    end else if (s5_r.late) begin
      wk_iso = 6'd1;
    end else begin
      wk_iso = iso_q;
    end

    s6_nxt = '0;
    if (s5_r.date_ok) begin
      s6_nxt.date_valid        = 1'b1;
      s6_nxt.leap_flag         = s5_r.leap;
      s6_nxt.ordinal_day       = s5_r.doy;
      s6_nxt.weekday_sunday    = s5_r.wd;
      s6_nxt.weekday_iso       = s5_r.iso;
      s6_nxt.week_sunday_based = s5_r.wk_sun;
      s6_nxt.week_iso          = wk_iso;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= wd_vld;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_r <= s5_nxt;
    s6_r <= s6_nxt;
  end

  assign out_vld  = s6_vld_r;
  assign out_item = s6_r;

endmodule

### rtl/gregorian_date_calendar_fields.sv
// Top level of the Gregorian date checker and calendar field generator.
// Depends on gdcf_pkg, gdcf_year, gdcf_weekday, gdcf_week and the assertion header.
//
// Usage: drive a date on in_item and raise start for one cycle per item. busy is
// always low, so an item is taken at every clock edge at which start is high.
// Each item gives exactly one result, shown on out_item for one cycle while
// out_strobe is high. The strobe rises after the item has passed through the
// register stages in order, and the result is accepted at the edge that ends
// the strobe. The pipeline has six register stages: the century quotient, the
// leap and date checks, the weekday sum, its reduction modulo seven, the week
// numbers, and the output register. Throughput is one item per cycle with no gaps.
// An invalid date gives date_valid low and every other field zero.
// The receiver cannot stall the block; results must be taken as they appear.
// A synchronous reset drops every item in flight and no strobe follows for them.
`include "gregorian_date_calendar_fields_assert.svh"
module gregorian_date_calendar_fields
  import gdcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  date_in_t  in_item,
  output logic      out_strobe,
  output date_out_t out_item
);

  logic   in_vld;
  logic   yr_vld;
  ydate_t yr;
  logic   wd_vld;
  wday_t  wd;

  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  gdcf_year u_year (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_item (in_item),
    .yr_vld  (yr_vld),
    .yr      (yr)
  );

  gdcf_weekday u_weekday (
    .clk    (clk),
    .rst_n  (rst_n),
    .yr_vld (yr_vld),
    .yr     (yr),
    .wd_vld (wd_vld),
    .wd     (wd)
  );

  gdcf_week u_week (
    .clk      (clk),
    .rst_n    (rst_n),
    .wd_vld   (wd_vld),
    .wd       (wd),
    .out_vld  (out_strobe),
    .out_item (out_item)
  );

  `GDCF_ASSERT_IMPLY(a_strobe_has_item, out_strobe, $past(in_vld, 6),
                     "Result without an item six cycles earlier.")
  `GDCF_ASSERT_IMPLY(a_valid_travels, wd_vld, $past(yr_vld, 2),
                     "Valid bit lost between year and weekday stages.")
  `GDCF_ASSERT_IMPLY(a_invalid_zero, out_strobe && !out_item.date_valid, out_item == '0,
                     "Invalid date with nonzero fields.")
  `GDCF_ASSERT_IMPLY(a_valid_nonzero, out_strobe && out_item.date_valid,
                     out_item.ordinal_day != 9'd0 && out_item.week_iso != 6'd0,
                     "Valid date with zero ordinal day or ISO week.")
  `GDCF_ASSERT_IMPLY(a_weekday_match, out_strobe && out_item.date_valid,
                     (out_item.weekday_iso == out_item.weekday_sunday) ||
                     (out_item.weekday_sunday == WD_SUNDAY && out_item.weekday_iso == ISO_SUNDAY),
                     "ISO weekday disagrees with Sunday-based weekday.")

endmodule

### sim/tb_gregorian_date_calendar_fields.sv
// Testbench for gregorian_date_calendar_fields: checks date validation and calendar fields.
// Drives directed and random dates in bursts and checks every result against a predictor.
// Depends on gdcf_pkg and the gregorian_date_calendar_fields RTL.
`timescale 1ns / 1ps

module tb_gregorian_date_calendar_fields;
  import gdcf_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned RANDOM_DATES = 400;
  localparam int unsigned DRAIN_CYCLES = 12;
  // Weekday month offsets, January in the low bits.
  localparam logic [35:0] MONTH_SHIFT = {3'd4, 3'd2, 3'd6, 3'd4, 3'd1, 3'd5,
                                         3'd3, 3'd0, 3'd5, 3'd2, 3'd3, 3'd0};

  typedef struct {
    bit       drain;
    date_in_t item;
  } planned_date_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  date_in_t  in_item = '0;
  logic      out_strobe;
  date_out_t out_item;

  planned_date_t plan[$];
  date_out_t     fields_due[$];
  int unsigned   total_items;
  int unsigned   taken = 0;
  int unsigned   errors = 0;
  int unsigned   burst_left = 1;
  int unsigned   gap_left = 0;
  int unsigned   idle_cycles = 0;

  gregorian_date_calendar_fields u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic leap_year(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  // Months other than February alternate 31 and 30, with the phase flipping at August.
  function automatic int unsigned days_in_month(input int unsigned mon, input logic leap);
    if (mon == 2) begin
      return 28 + leap;
    end
    return 30 + ((mon ^ (mon >> 3)) & 1);
  endfunction

  function automatic date_out_t calendar_fields(input date_in_t d);
    date_out_t   r;
    int unsigned yy, mm, dd, doy, y, wd, iso, thu, dec31, ylen;
    logic        leap, prev_leap;
    r = '0;
    yy = d.year_value;
    mm = d.month_value;
    dd = d.day_value;
    if (yy > YEAR_MAX || mm < 1 || mm > 12 || dd < 1) begin
      return r;
    end
    leap = leap_year(yy);
    if (dd > days_in_month(mm, leap)) begin
      return r;
    end
    doy = dd;
    for (int unsigned m = 1; m < mm; m++) begin
      doy += days_in_month(m, leap);
    end
    y = yy + YEAR_SHIFT;
    if (mm < 3) begin
      y -= 1;
    end
    wd = (y + y / 4 - y / 100 + y / 400 + MONTH_SHIFT[3 * (mm - 1) +: 3] + dd) % 7;
    iso = (wd == WD_SUNDAY) ? ISO_SUNDAY : wd;
    r.date_valid = 1'b1;
    r.leap_flag = leap;
    r.ordinal_day = 9'(doy);
    r.weekday_sunday = 3'(wd);
    r.weekday_iso = 3'(iso);
    r.week_sunday_based = 6'((doy - 1 + 7 - wd) / 7);
    thu = doy + 4;
    if (thu <= iso) begin
      // The Thursday of this week falls in the previous year.
      dec31 = (iso + 14 - doy - 1) % 7 + 1;
      prev_leap = (yy >= 1) ? leap_year(yy - 1) : 1'b0;
      r.week_iso = (dec31 == DEC31_THU || (dec31 == DEC31_FRI && prev_leap)) ?
                   WEEK_LONG : WEEK_SHORT;
    end else begin
      thu -= iso;
      ylen = leap ? LEAP_YEAR_LEN : YEAR_LEN;
      r.week_iso = (thu > ylen) ? 6'd1 : 6'((thu - 1) / 7 + 1);
    end
    return r;
  endfunction

  task automatic queue_date(input int unsigned yr, input int unsigned mon,
                            input int unsigned dy, input bit drain);
    planned_date_t p;
    p.drain = drain;
    p.item.year_value = 14'(yr);
    p.item.month_value = 4'(mon);
    p.item.day_value = 5'(dy);
    plan.push_back(p);
  endtask

  task automatic field_check(input string name, input logic [8:0] want,
                             input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : drive
    planned_date_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        fields_due.push_back(calendar_fields(in_item));
        taken++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (plan.size() != 0 && !(plan[0].drain && fields_due.size() != 0)) begin
        nxt = plan.pop_front();
        in_item <= nxt.item;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check
    date_out_t want;
    if (rst_n && out_strobe) begin
      if (fields_due.size() == 0) begin
        $error("out_item: expected no result, actual %p", out_item);
        errors++;
      end else begin
        want = fields_due.pop_front();
        field_check("date_valid", want.date_valid, out_item.date_valid);
        field_check("leap_flag", want.leap_flag, out_item.leap_flag);
        field_check("ordinal_day", want.ordinal_day, out_item.ordinal_day);
        field_check("weekday_sunday", want.weekday_sunday, out_item.weekday_sunday);
        field_check("weekday_iso", want.weekday_iso, out_item.weekday_iso);
        field_check("week_sunday_based", want.week_sunday_based,
                    out_item.week_sunday_based);
        field_check("week_iso", want.week_iso, out_item.week_iso);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned yr, mon, dy, pick;
    queue_date(0, 1, 1, 0);
    queue_date(0, 1, 2, 0);
    queue_date(1, 1, 1, 0);
    queue_date(9999, 12, 31, 0);
    queue_date(9999, 1, 1, 0);
    queue_date(10000, 1, 1, 0);
    queue_date(16383, 15, 31, 0);
    queue_date(0, 0, 0, 0);
    queue_date(2024, 13, 1, 0);
    queue_date(2023, 2, 29, 0);
    queue_date(2024, 2, 29, 0);
    queue_date(2000, 2, 29, 0);
    queue_date(1900, 2, 29, 0);
    queue_date(2024, 4, 31, 0);
    queue_date(2024, 6, 0, 0);
    queue_date(2021, 1, 1, 0);
    queue_date(2016, 1, 1, 0);
    queue_date(2005, 1, 1, 0);
    queue_date(2010, 1, 3, 0);
    queue_date(2024, 12, 30, 0);
    queue_date(2019, 12, 31, 0);
    queue_date(2020, 12, 31, 0);
    queue_date(2012, 12, 31, 0);
    queue_date(2023, 1, 1, 0);
    for (int unsigned n = 0; n < RANDOM_DATES; n++) begin
      case ($urandom_range(0, 7))
        0: yr = $urandom_range(0, 4);
        1: yr = 100 * $urandom_range(0, 99);
        2: yr = $urandom_range(9995, 9999);
        default: yr = $urandom_range(0, 9999);
      endcase
      case ($urandom_range(0, 5))
        0: begin
          mon = 1;
          dy = $urandom_range(1, 7);
        end
        1: begin
          mon = 12;
          dy = $urandom_range(25, 31);
        end
        2: begin
          mon = 2;
          dy = $urandom_range(27, days_in_month(2, leap_year(yr)));
        end
        default: begin
          mon = $urandom_range(1, 12);
          dy = $urandom_range(1, days_in_month(mon, leap_year(yr)));
        end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        yr = $urandom_range(0, 16383);
        mon = $urandom_range(0, 15);
        dy = $urandom_range(0, 31);
      end else if (pick < 22) begin
        dy = days_in_month(mon, leap_year(yr)) + 1;
      end
      queue_date(yr, mon, dy, n == 0 || $urandom_range(0, 99) == 0);
    end
    total_items = plan.size();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (!(taken == total_items && fields_due.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/gdcf_pkg.sv
rtl/gdcf_year.sv
rtl/gdcf_weekday.sv
rtl/gdcf_week.sv
rtl/gregorian_date_calendar_fields.sv
sim/tb_gregorian_date_calendar_fields.sv
